// ----- rtl/core/almost_shortest_path_engine_top_defines.svh -----
// Assertion macros shared by the checker
`ifndef ALMOST_SHORTEST_PATH_ENGINE_TOP_DEFINES_SVH
`define ALMOST_SHORTEST_PATH_ENGINE_TOP_DEFINES_SVH
`define ASP_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assertion failed");
`define ASP_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`endif

// ----- rtl/core/asp_pkg.sv -----
`timescale 1ns / 1ps
package asp_pkg;
  localparam int MAX_NODES = 512;
  localparam int MAX_EDGES = 16384;
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int EDGE_W = $clog2(MAX_EDGES);
  localparam int CNT_W = EDGE_W + 1;
  localparam int DIST_W = 19;
  localparam int LEN_W = 10;
  localparam int NCNT_W = 10;
  localparam int CFG_W = 10;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_SOLVE = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] tail;
    logic [NODE_W-1:0] head;
    logic [LEN_W-1:0] len;
  } edge_t;

  typedef struct packed {
    logic kind;
    logic [8:0] from_node;
    logic [8:0] to_node;
    logic [9:0] weight;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic [DIST_W-1:0] distance;
    logic dropped_edges;
  } out_item_t;

  // edge store write request from the loader
  typedef struct packed {
    logic we;
    logic [EDGE_W-1:0] addr;
    edge_t data;
  } edge_wr_t;
endpackage

// ----- rtl/core/asp_if.sv -----
`timescale 1ns / 1ps
interface asp_in_if import asp_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface asp_out_if import asp_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/asp_edge_mem.sv -----
`timescale 1ns / 1ps
module asp_edge_mem import asp_pkg::*; (
  input  logic clk,
  input  edge_wr_t wr,
  input  logic [EDGE_W-1:0] rd_addr,
  output edge_t rd_data
);
  edge_t mem [MAX_EDGES];
  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- rtl/core/asp_solver.sv -----
`timescale 1ns / 1ps
// Sweeps the edge store each round; node distances live in a 2R1W memory.
// Per edge: S_EDGE addresses the edge, S_WAIT reads the tail+head node entries,
// S_NODE compares/writes, S_CHECK advances.
module asp_solver import asp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [NCNT_W-1:0] n_live,
  input  logic [NODE_W-1:0] src,
  input  logic [NODE_W-1:0] dst,
  input  logic [CNT_W-1:0] n_edges,
  output logic [EDGE_W-1:0] e_addr,
  input  edge_t e_data,
  output logic done,
  output logic found,
  output logic [DIST_W-1:0] path_dist
);
  typedef enum logic [2:0] {S_IDLE, S_INIT, S_EDGE, S_WAIT, S_NODE, S_CHECK, S_FIN}
    state_t;
  typedef enum logic [1:0] {P_SP, P_MARK, P_ALT} pass_t;
  state_t state;
  pass_t pass;

  // node store: {unreached, reach, distance}; mark bits in own memory
  logic [DIST_W+1:0] node_mem [MAX_NODES];
  logic mark_mem [MAX_EDGES];
  logic [DIST_W+1:0] ta, hb;
  logic mk;
  logic [NODE_W:0] ncnt;
  logic [CNT_W-1:0] ecnt;
  logic [NCNT_W:0] round;
  logic changed;
  edge_t ed;

  logic [DIST_W:0] sum;
  logic [DIST_W-1:0] nd;
  logic live, tight, relax, markit;
  always_comb begin
    sum = {1'b0, ta[DIST_W-1:0]} + {{(DIST_W+1-LEN_W){1'b0}}, ed.len};
    nd = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    live = ({1'b0, ed.tail} < n_live) && ({1'b0, ed.head} < n_live);
    tight = !ta[DIST_W+1] && !hb[DIST_W+1] && nd == hb[DIST_W-1:0];
    relax = live && !ta[DIST_W+1] && !(pass == P_ALT && mk)
            && (hb[DIST_W+1] || nd < hb[DIST_W-1:0]);
    markit = live && !mk && ed.tail != dst && hb[DIST_W] && tight;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      pass <= P_SP;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          pass <= P_SP;
          ncnt <= '0;
          state <= S_INIT;
        end
        S_INIT: begin
          // per-node reset; reach bit cleared for the alternate pass
          if (pass == P_SP)
            node_mem[ncnt[NODE_W-1:0]] <= {ncnt[NODE_W-1:0] != src,
                                           ncnt[NODE_W-1:0] == dst, {DIST_W{1'b0}}};
          else
            node_mem[ncnt[NODE_W-1:0]] <= {ncnt[NODE_W-1:0] != src, 1'b0,
                                           {DIST_W{1'b0}}};
          if ({1'b0, ncnt} + 1'b1 >= {1'b0, n_live}) begin
            ecnt <= '0; round <= '0; changed <= 1'b0;
            state <= (n_edges == '0) ? S_FIN : S_EDGE;
          end
          ncnt <= ncnt + 1'b1;
        end
        S_EDGE: state <= S_WAIT; // e_addr presented, data next cycle
        S_WAIT: begin
          ed <= e_data;
          ta <= node_mem[e_data.tail];
          hb <= node_mem[e_data.head];
          if (pass == P_SP || (pass == P_MARK && round == '0)) mk <= 1'b0;
          else mk <= mark_mem[ecnt[EDGE_W-1:0]];
          state <= S_NODE;
        end
        S_NODE: begin
          if (pass == P_MARK) begin
            if (markit) begin
              mark_mem[ecnt[EDGE_W-1:0]] <= 1'b1;
              node_mem[ed.tail] <= {ta[DIST_W+1], 1'b1, ta[DIST_W-1:0]};
              changed <= 1'b1;
            end else if (round == '0) mark_mem[ecnt[EDGE_W-1:0]] <= 1'b0;
            // first mark round must clear stale bits: mk read as 0 then
          end else if (relax) begin
            node_mem[ed.head] <= {1'b0, hb[DIST_W], nd};
            changed <= 1'b1;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (ecnt + 1'b1 < n_edges) begin
            ecnt <= ecnt + 1'b1;
            state <= S_EDGE;
          end else if (changed && round < {1'b0, n_live}) begin
            ecnt <= '0; changed <= 1'b0; round <= round + 1'b1;
            state <= S_EDGE;
          end else if (pass == P_SP) begin
            pass <= P_MARK; ecnt <= '0; changed <= 1'b0; round <= '0;
            state <= S_EDGE;
          end else if (pass == P_MARK) begin
            pass <= P_ALT; ncnt <= '0;
            state <= S_INIT;
          end else state <= S_FIN;
        end
        S_FIN: begin
          ta <= node_mem[dst];
          state <= S_IDLE;
          done <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign e_addr = ecnt[EDGE_W-1:0];
  assign found = !ta[DIST_W+1];
  assign path_dist = ta[DIST_W-1:0];
endmodule

// ----- rtl/core/almost_shortest_path_engine_top.sv -----
`timescale 1ns / 1ps
// channel  dir  payload
// in_ch    in   kind, from_node, to_node, weight
// out_ch   out  found, distance, dropped_edges
// cfg      in   cfg_we, cfg_index, cfg_data
// Solve item: node init before the first and the last pass, then a sweep of
// every edge in each round of the three passes, up to n+1 rounds per pass,
// then the result is read from the node memory. A solve with source or target
// out of range skips the solver.
// Synchronous reset clears control; memories are not cleared.
// Input is held off while a solve runs or its result waits to be taken.
module almost_shortest_path_engine_top import asp_pkg::*; (
  input  logic clk,
  input  logic rst,
  asp_in_if.sink in_ch,
  asp_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  logic [NCNT_W-1:0] node_count;
  logic [NODE_W-1:0] source_node, target_node;
  logic [CNT_W-1:0] edge_count;
  logic drop_seen, busy, start, done, s_found;
  logic [DIST_W-1:0] s_dist;
  logic [EDGE_W-1:0] s_addr;
  logic [NCNT_W-1:0] n_live;
  edge_wr_t wr;
  edge_t rd;
  logic acc, bad, ok_st;

  assign n_live = (node_count > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count;
  assign in_ch.ready = !busy && !out_ch.valid;
  assign acc = in_ch.valid && in_ch.ready;
  assign bad = ({1'b0, in_ch.data.from_node} >= n_live) ||
               ({1'b0, in_ch.data.to_node} >= n_live) ||
               (edge_count >= CNT_W'(MAX_EDGES));
  assign ok_st = ({1'b0, source_node} < n_live) && ({1'b0, target_node} < n_live);
  assign wr.we = acc && in_ch.data.kind == KIND_ADD && !bad;
  assign wr.addr = edge_count[EDGE_W-1:0];
  assign wr.data = '{tail: in_ch.data.from_node, head: in_ch.data.to_node,
                     len: in_ch.data.weight};
  assign start = acc && in_ch.data.kind == KIND_SOLVE && ok_st;

  asp_edge_mem u_mem (.clk, .wr, .rd_addr(s_addr), .rd_data(rd));
  asp_solver u_solve (.clk, .rst, .start, .n_live, .src(source_node),
    .dst(target_node), .n_edges(edge_count), .e_addr(s_addr), .e_data(rd),
    .done, .found(s_found), .path_dist(s_dist));

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NCNT_W'(1); source_node <= '0; target_node <= '0;
      edge_count <= '0; drop_seen <= 1'b0; busy <= 1'b0; out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_COUNT: node_count <= cfg_data;
          REG_SOURCE: source_node <= cfg_data[NODE_W-1:0];
          REG_TARGET: target_node <= cfg_data[NODE_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (acc && in_ch.data.kind == KIND_ADD) begin
        if (bad) drop_seen <= 1'b1;
        else edge_count <= edge_count + 1'b1;
      end
      if (acc && in_ch.data.kind == KIND_SOLVE) begin
        out_ch.data.dropped_edges <= drop_seen;
        if (ok_st) busy <= 1'b1;
        else begin
          out_ch.valid <= 1'b1;
          out_ch.data.found <= 1'b0;
          out_ch.data.distance <= '0;
          edge_count <= '0; drop_seen <= 1'b0;
        end
      end
      if (done) begin
        busy <= 1'b0;
        out_ch.valid <= 1'b1;
        out_ch.data.found <= s_found;
        out_ch.data.distance <= s_found ? s_dist : '0;
        edge_count <= '0; drop_seen <= 1'b0;
      end
    end
  end
endmodule

// ----- rtl/core/asp_checker.sv -----
`timescale 1ns / 1ps
`include "almost_shortest_path_engine_top_defines.svh"
module asp_checker import asp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_kind,
  input logic out_valid,
  input logic out_ready,
  input logic out_found,
  input logic [DIST_W-1:0] out_distance
);
  `ASP_ASSERT_IMP(a_nf_zero, clk, rst, out_valid && !out_found, out_distance == '0)
  `ASP_ASSERT_IMP(a_hold_in, clk, rst, out_valid, !in_ready)
  `ASP_ASSERT_NXT(a_solve_busy, clk, rst, in_valid && in_ready && in_kind == KIND_SOLVE,
    !in_ready)
  `ASP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_distance))
endmodule

bind almost_shortest_path_engine_top asp_checker u_chk (.clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.data.kind),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_found(out_ch.data.found),
  .out_distance(out_ch.data.distance));
